// ===== src/kmc_pkg.sv =====
// Shared types and constants of the k-means colour clustering unit.
`default_nettype none
package kmc_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF   = 24;

  localparam int COLOR_W   = 8;
  localparam int SLOT_W    = 4;
  localparam int IDX_OUT_W = 4;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CC_RESET = 5'd16;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_CLASS = 2'd1;
  localparam logic [1:0] REQ_PASS  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_CENTRE = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACCUM,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLASS,
    ST_DSTART,
    ST_DRUN,
    ST_DDONE
  } state_e;

endpackage
`default_nettype wire

// ===== src/kmc_div_lane.sv =====
// Restoring divider lane: one quotient bit per step.
`default_nettype none
module kmc_div_lane import kmc_pkg::*; #(
  parameter int SUM_W = 36,
  parameter int CNT_W = 24,
  parameter int QW    = 12
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [SUM_W-1:0] sum_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic      [QW-1:0]    quo_o
);

  localparam int W = (SUM_W > CNT_W + QW) ? SUM_W : CNT_W + QW;

  logic [W-1:0]  rem_q;
  logic [W-1:0]  dv_q;
  logic [QW-1:0] quo_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= W'(sum_i);
      dv_q  <= W'(cnt_i) << (QW - 1);
      quo_q <= '0;
    end else if (step_i) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire

// ===== src/kmc_cell.sv =====
// One centre cell: centre, running sums and count, plus a token stage for the nearest search.
`default_nettype none
module kmc_cell import kmc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic                 act_i,
  input  wire logic [2*COORD_BITS+3*COLOR_W-1:0] pix_i,
  input  wire logic                 tok_vld_i,
  input  wire logic [((2*COORD_BITS > 16) ? 2*COORD_BITS : 16)+2:0] tok_d_i,
  input  wire logic [IDX_W-1:0]     tok_idx_i,
  input  wire logic [3*COLOR_W-1:0] tok_rgb_i,
  output logic                      tok_vld_o,
  output logic [((2*COORD_BITS > 16) ? 2*COORD_BITS : 16)+2:0] tok_d_o,
  output logic [IDX_W-1:0]          tok_idx_o,
  output logic [3*COLOR_W-1:0]      tok_rgb_o,
  input  wire logic [2*COORD_BITS+3*COLOR_W-1:0] ctr_nb_i,
  input  wire logic [2*(COORD_BITS+COUNT_BITS)+3*(COLOR_W+COUNT_BITS)+COUNT_BITS-1:0] acc_nb_i,
  output logic [2*COORD_BITS+3*COLOR_W-1:0] ctr_o,
  output logic [2*(COORD_BITS+COUNT_BITS)+3*(COLOR_W+COUNT_BITS)+COUNT_BITS-1:0] acc_o
);

  localparam int C     = COORD_BITS;
  localparam int N     = COUNT_BITS;
  localparam int SXW   = C + N;
  localparam int SCW   = COLOR_W + N;
  localparam int DW    = ((2*C > 16) ? 2*C : 16) + 3;
  localparam int CTR_W = 2*C + 3*COLOR_W;

  logic [C-1:0]       cx_q, cy_q, px, py, dx, dy;
  logic [COLOR_W-1:0] cr_q, cg_q, cb_q, pr, pg, pb, dr, dg, db;
  logic [SXW-1:0]     sx_q, sy_q;
  logic [SCW-1:0]     sr_q, sg_q, sb_q;
  logic [N-1:0]       cnt_q;
  logic [2*C-1:0]     sqx, sqy;
  logic [15:0]        sqr, sqg, sqb;
  logic [DW-1:0]      sq_dist, tok_d_q;
  logic               take, tok_vld_q;
  logic [IDX_W-1:0]   tok_idx_q;
  logic [3*COLOR_W-1:0] tok_rgb_q;

  assign {px, py, pr, pg, pb} = pix_i;

  assign dx = (px >= cx_q) ? px - cx_q : cx_q - px;
  assign dy = (py >= cy_q) ? py - cy_q : cy_q - py;
  assign dr = (pr >= cr_q) ? pr - cr_q : cr_q - pr;
  assign dg = (pg >= cg_q) ? pg - cg_q : cg_q - pg;
  assign db = (pb >= cb_q) ? pb - cb_q : cb_q - pb;
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqr = dr * dr;
  assign sqg = dg * dg;
  assign sqb = db * db;
  assign sq_dist = DW'(sqx) + DW'(sqy) + DW'(sqr) + DW'(sqg) + DW'(sqb);

  // The first cell always takes the token; later cells take it only on a strictly
  // smaller distance, so ties stay with the lower index.
  assign take = act_i && ((IDX == 0) || (sq_dist < tok_d_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      if (take) begin
        tok_d_q   <= sq_dist;
        tok_idx_q <= IDX_W'(IDX);
        tok_rgb_q <= {cr_q, cg_q, cb_q};
      end else begin
        tok_d_q   <= tok_d_i;
        tok_idx_q <= tok_idx_i;
        tok_rgb_q <= tok_rgb_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {cx_q, cy_q, cr_q, cg_q, cb_q} <= '0;
      {sx_q, sy_q, sr_q, sg_q, sb_q, cnt_q} <= '0;
    end else begin
      case (ctrl_i.op)
        OP_LOAD: begin
          if (ctrl_i.sel) begin
            {cx_q, cy_q, cr_q, cg_q, cb_q} <= pix_i;
          end
        end
        OP_ACCUM: begin
          if (ctrl_i.sel && (cnt_q != '1)) begin
            cnt_q <= cnt_q + N'(1);
            sx_q  <= sx_q + SXW'(px);
            sy_q  <= sy_q + SXW'(py);
            sr_q  <= sr_q + SCW'(pr);
            sg_q  <= sg_q + SCW'(pg);
            sb_q  <= sb_q + SCW'(pb);
          end
        end
        OP_SHIFT: begin
          {cx_q, cy_q, cr_q, cg_q, cb_q} <= ctr_nb_i;
          {sx_q, sy_q, sr_q, sg_q, sb_q, cnt_q} <= acc_nb_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_d_o   = tok_d_q;
  assign tok_idx_o = tok_idx_q;
  assign tok_rgb_o = tok_rgb_q;
  assign ctr_o     = CTR_W'({cx_q, cy_q, cr_q, cg_q, cb_q});
  assign acc_o     = {sx_q, sy_q, sr_q, sg_q, sb_q, cnt_q};

endmodule
`default_nettype wire

// ===== src/kmeans_colour_pixel_clustering_unit.sv =====
// Top level of the k-means colour clustering unit: request control, cell row and dividers.
//
//  channel   handshake                    payload
//  request   start / busy                 req_type, centre_slot, pixel_x/y, red/green/blue
//  result    result_strobe_o (one cycle)  result_kind ... last
//  config    cfg_valid_i / cfg_ready_o    cfg_data_i (cluster count)
//
// A classify sends the search token along the cell row one cell per cycle, then the
// winning cell accumulates the pixel.
// An end of pass runs QW = max(COORD_BITS, 8) divider steps per active centre and skips
// inactive slots, as the row rotates once through the dividers.
// Reset clears all centres, sums and counts at once; no clearing pass is needed.
// Results are shown for one cycle and cannot be held off.
`default_nettype none
module kmeans_colour_pixel_clustering_unit import kmc_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [SLOT_W-1:0]     centre_slot_i,
  input  wire logic [COORD_BITS-1:0] pixel_x_i,
  input  wire logic [COORD_BITS-1:0] pixel_y_i,
  input  wire logic [COLOR_W-1:0]    red_in_i,
  input  wire logic [COLOR_W-1:0]    green_in_i,
  input  wire logic [COLOR_W-1:0]    blue_in_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  output logic                       result_strobe_o,
  output logic                       result_kind_o,
  output logic [IDX_OUT_W-1:0]       cluster_index_o,
  output logic [COORD_BITS-1:0]      centre_x_o,
  output logic [COORD_BITS-1:0]      centre_y_o,
  output logic [COLOR_W-1:0]         centre_red_o,
  output logic [COLOR_W-1:0]         centre_green_o,
  output logic [COLOR_W-1:0]         centre_blue_o,
  output logic [COUNT_BITS-1:0]      member_count_o,
  output logic                       unchanged_o,
  output logic                       converged_o,
  output logic                       last_o
);

  localparam int C     = COORD_BITS;
  localparam int N     = COUNT_BITS;
  localparam int SXW   = C + N;
  localparam int SCW   = COLOR_W + N;
  localparam int DW    = ((2*C > 16) ? 2*C : 16) + 3;
  localparam int CTR_W = 2*C + 3*COLOR_W;
  localparam int ACC_W = 2*SXW + 3*SCW + N;
  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int NW    = $clog2(MAX_CLUSTERS + 1);
  localparam int QW    = (C > COLOR_W) ? C : COLOR_W;
  localparam int IT_W  = $clog2(QW);

  state_e state_q, state_d;

  logic             accept;
  logic [CFG_W-1:0] cc_q;
  logic [NW-1:0]    n_act;
  logic             inj_q;
  logic [CTR_W-1:0] pix_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IDX_W-1:0] e_q, e_d;
  logic [IT_W-1:0]  it_q, it_d;
  logic             all_same_q, all_same_d;
  logic             e_act, e_end, e_last;

  logic             tok_vld [0:MAX_CLUSTERS];
  logic [DW-1:0]    tok_d   [0:MAX_CLUSTERS];
  logic [IDX_W-1:0] tok_idx [0:MAX_CLUSTERS];
  logic [3*COLOR_W-1:0] tok_rgb [0:MAX_CLUSTERS];
  logic [CTR_W-1:0] ctr_w   [0:MAX_CLUSTERS];
  logic [ACC_W-1:0] acc_w   [0:MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] act;
  logic [MAX_CLUSTERS-1:0] sel;
  cell_op_e         op;
  logic [CTR_W-1:0] shift_ctr;

  logic             lane_load, lane_step;
  logic [QW-1:0]    qx, qy, qr, qg, qb;
  logic [N-1:0]     cnt0;
  logic [SXW-1:0]   sx0, sy0;
  logic [SCW-1:0]   sr0, sg0, sb0;
  logic [CTR_W-1:0] nc;
  logic             same;

  logic             res_vld_d;
  logic             res_kind_d, res_unch_d, res_conv_d, res_last_d;
  logic [IDX_OUT_W-1:0] res_idx_d;
  logic [CTR_W-1:0] res_ctr_d;
  logic [N-1:0]     res_cnt_d;
  logic             res_strobe_q;
  logic             res_kind_q, res_unch_q, res_conv_q, res_last_q;
  logic [IDX_OUT_W-1:0] res_idx_q;
  logic [CTR_W-1:0] res_ctr_q;
  logic [N-1:0]     res_cnt_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // A count of zero acts as one; counts above the row length act as the row length.
  always_comb begin
    if (cc_q == '0) begin
      n_act = NW'(1);
    end else if (32'(cc_q) > MAX_CLUSTERS) begin
      n_act = NW'(MAX_CLUSTERS);
    end else begin
      n_act = NW'(cc_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      act[i] = (NW'(i) < n_act);
    end
  end

  assign e_act  = (NW'(e_q) < n_act);
  assign e_end  = (e_q == IDX_W'(MAX_CLUSTERS - 1));
  assign e_last = (NW'(e_q) == n_act - NW'(1));

  // Cell row. The search token enters at cell 0; on a shift every cell takes its upper
  // neighbor's contents and the top cell takes the new centre (cell 0's, if inactive).
  assign tok_vld[0] = inj_q;
  assign tok_d[0]   = '0;
  assign tok_idx[0] = '0;
  assign tok_rgb[0] = '0;
  assign ctr_w[MAX_CLUSTERS] = shift_ctr;
  assign acc_w[MAX_CLUSTERS] = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [CTR_W-1:0] ctr_o;
    logic [ACC_W-1:0] acc_o;

    assign ctrl.op  = op;
    assign ctrl.sel = sel[g];

    kmc_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .act_i     (act[g]),
      .pix_i     (pix_q),
      .tok_vld_i (tok_vld[g]),
      .tok_d_i   (tok_d[g]),
      .tok_idx_i (tok_idx[g]),
      .tok_rgb_i (tok_rgb[g]),
      .tok_vld_o (tok_vld[g+1]),
      .tok_d_o   (tok_d[g+1]),
      .tok_idx_o (tok_idx[g+1]),
      .tok_rgb_o (tok_rgb[g+1]),
      .ctr_nb_i  (ctr_w[g+1]),
      .acc_nb_i  (acc_w[g+1]),
      .ctr_o     (ctr_o),
      .acc_o     (acc_o)
    );

    assign ctr_w[g] = ctr_o;
    assign acc_w[g] = acc_o;
  end

  assign cnt0 = acc_w[0][N-1:0];
  assign sb0  = acc_w[0][N +: SCW];
  assign sg0  = acc_w[0][N+SCW +: SCW];
  assign sr0  = acc_w[0][N+2*SCW +: SCW];
  assign sy0  = acc_w[0][N+3*SCW +: SXW];
  assign sx0  = acc_w[0][N+3*SCW+SXW +: SXW];

  kmc_div_lane #(.SUM_W(SXW), .CNT_W(N), .QW(QW)) u_div_x (
    .clk_i(clk_i), .load_i(lane_load), .step_i(lane_step), .sum_i(sx0), .cnt_i(cnt0),
    .quo_o(qx)
  );
  kmc_div_lane #(.SUM_W(SXW), .CNT_W(N), .QW(QW)) u_div_y (
    .clk_i(clk_i), .load_i(lane_load), .step_i(lane_step), .sum_i(sy0), .cnt_i(cnt0),
    .quo_o(qy)
  );
  kmc_div_lane #(.SUM_W(SCW), .CNT_W(N), .QW(QW)) u_div_r (
    .clk_i(clk_i), .load_i(lane_load), .step_i(lane_step), .sum_i(sr0), .cnt_i(cnt0),
    .quo_o(qr)
  );
  kmc_div_lane #(.SUM_W(SCW), .CNT_W(N), .QW(QW)) u_div_g (
    .clk_i(clk_i), .load_i(lane_load), .step_i(lane_step), .sum_i(sg0), .cnt_i(cnt0),
    .quo_o(qg)
  );
  kmc_div_lane #(.SUM_W(SCW), .CNT_W(N), .QW(QW)) u_div_b (
    .clk_i(clk_i), .load_i(lane_load), .step_i(lane_step), .sum_i(sb0), .cnt_i(cnt0),
    .quo_o(qb)
  );

  // An empty cluster becomes the all-zero centre.
  assign nc   = (cnt0 == '0) ? '0 :
                {qx[C-1:0], qy[C-1:0], qr[COLOR_W-1:0], qg[COLOR_W-1:0], qb[COLOR_W-1:0]};
  assign same = (nc == ctr_w[0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_LOAD:  state_d = ST_LOAD;
            REQ_CLASS: state_d = ST_CLASS;
            REQ_PASS:  state_d = ST_DSTART;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_d = ST_IDLE;
      ST_CLASS: begin
        if (tok_vld[MAX_CLUSTERS]) begin
          state_d = ST_IDLE;
        end
      end
      ST_DSTART: begin
        if (e_act) begin
          state_d = ST_DRUN;
        end else if (e_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRUN: begin
        if (it_q == '0) begin
          state_d = ST_DDONE;
        end
      end
      ST_DDONE: state_d = e_end ? ST_IDLE : ST_DSTART;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op         = OP_NONE;
    sel        = '0;
    shift_ctr  = ctr_w[0];
    lane_load  = 1'b0;
    lane_step  = 1'b0;
    e_d        = e_q;
    it_d       = it_q;
    all_same_d = all_same_q;
    res_vld_d  = 1'b0;
    res_kind_d = KIND_PIXEL;
    res_idx_d  = '0;
    res_ctr_d  = '0;
    res_cnt_d  = '0;
    res_unch_d = 1'b0;
    res_conv_d = 1'b0;
    res_last_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_PASS)) begin
          e_d        = '0;
          all_same_d = 1'b1;
        end
      end
      ST_LOAD: begin
        op = OP_LOAD;
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          sel[i] = (32'(slot_q) == 32'(i));
        end
      end
      ST_CLASS: begin
        if (tok_vld[MAX_CLUSTERS]) begin
          op = OP_ACCUM;
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sel[i] = (32'(tok_idx[MAX_CLUSTERS]) == 32'(i));
          end
          res_vld_d  = 1'b1;
          res_kind_d = KIND_PIXEL;
          res_idx_d  = IDX_OUT_W'(tok_idx[MAX_CLUSTERS]);
          res_ctr_d  = CTR_W'(tok_rgb[MAX_CLUSTERS]);
          res_last_d = 1'b1;
        end
      end
      ST_DSTART: begin
        if (e_act) begin
          lane_load = 1'b1;
          it_d      = IT_W'(QW - 1);
        end else begin
          op  = OP_SHIFT;
          sel = '1;
          e_d = e_q + IDX_W'(1);
        end
      end
      ST_DRUN: begin
        lane_step = 1'b1;
        it_d      = it_q - IT_W'(1);
      end
      ST_DDONE: begin
        op         = OP_SHIFT;
        sel        = '1;
        shift_ctr  = nc;
        e_d        = e_q + IDX_W'(1);
        all_same_d = all_same_q && same;
        res_vld_d  = 1'b1;
        res_kind_d = KIND_CENTRE;
        res_idx_d  = IDX_OUT_W'(e_q);
        res_ctr_d  = nc;
        res_cnt_d  = cnt0;
        res_unch_d = same;
        res_conv_d = e_last && all_same_q && same;
        res_last_d = e_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cc_q         <= CC_RESET;
      inj_q        <= 1'b0;
      res_strobe_q <= 1'b0;
      e_q          <= '0;
      it_q         <= '0;
      all_same_q   <= 1'b1;
    end else begin
      state_q      <= state_d;
      inj_q        <= accept && (req_type_i == REQ_CLASS);
      res_strobe_q <= res_vld_d;
      e_q          <= e_d;
      it_q         <= it_d;
      all_same_q   <= all_same_d;
      if (cfg_valid_i) begin
        cc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= {pixel_x_i, pixel_y_i, red_in_i, green_in_i, blue_in_i};
      slot_q <= centre_slot_i;
    end
    if (res_vld_d) begin
      res_kind_q <= res_kind_d;
      res_idx_q  <= res_idx_d;
      res_ctr_q  <= res_ctr_d;
      res_cnt_q  <= res_cnt_d;
      res_unch_q <= res_unch_d;
      res_conv_q <= res_conv_d;
      res_last_q <= res_last_d;
    end
  end

  assign result_strobe_o = res_strobe_q;
  assign result_kind_o   = res_kind_q;
  assign cluster_index_o = res_idx_q;
  assign centre_x_o      = res_ctr_q[24+C +: C];
  assign centre_y_o      = res_ctr_q[24 +: C];
  assign centre_red_o    = res_ctr_q[16 +: COLOR_W];
  assign centre_green_o  = res_ctr_q[8 +: COLOR_W];
  assign centre_blue_o   = res_ctr_q[0 +: COLOR_W];
  assign member_count_o  = res_cnt_q;
  assign unchanged_o     = res_unch_q;
  assign converged_o     = res_conv_q;
  assign last_o          = res_last_q;

endmodule
`default_nettype wire
